// File: rtl/hpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine package
// Shared types, codes and constants for the histogram percentile engine.
// ----------------------------------------------------------------------------
package hpe_pkg;

   localparam int MAX_BINS_DEF   = 256;
   localparam int COUNT_BITS_DEF = 32;
   localparam int BINS_W         = 9;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_VAF   = 2'd1;
   localparam logic [1:0] MODE_FAV   = 2'd2;
   // The fourth mode code is unused and a transaction carrying it is dropped.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS      = 2'd2;

   localparam logic signed [31:0] DATA_LOW_RST  = 32'sd0;
   localparam logic signed [31:0] DATA_HIGH_RST = 32'sd16777216;
   localparam logic [BINS_W-1:0]  BINS_RST      = 9'd256;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         bin_index;
      logic [31:0]        bin_count;
      logic [16:0]        fraction;
      logic signed [31:0] query_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [16:0]        result_fraction;
      logic               histogram_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_POS_MUL, ST_POS_DIV, ST_SUM_INIT, ST_SUM,
      ST_CHECK, ST_TGT_MUL, ST_FIND_INIT, ST_FIND, ST_WITHIN_DIV, ST_OFF_MUL,
      ST_OFF_DIV, ST_NUM_MUL, ST_NUM_DIV, ST_EMIT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_SET_BAD, DP_POS_MUL, DP_POS_DIV, DP_SUM_INIT, DP_SUM,
      DP_SET_EARLY, DP_TGT_MUL, DP_FIND_INIT, DP_FIND, DP_SET_HIGH, DP_WITHIN_DIV,
      DP_OFF_MUL, DP_OFF_DIV, DP_NUM_MUL, DP_NUM_DIV, DP_PUSH
   } dp_op_type;

   typedef struct packed {
      logic      ready;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic span_ok;
      logic in_query;
      logic is_vaf;
      logic early;
      logic walk_done;
      logic hit;
      logic cnt_zero;
      logic arith_done;
      logic slot_free;
   } ctrl_status_type;

endpackage

// File: rtl/hpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/hpe_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential multiply / divide unit
// Shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module hpe_arith #(
   parameter int W = 58
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         is_div,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          div_ff, div_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  mpd_ff, mpd_in;
   logic [W-1:0]  mpr_ff, mpr_in;
   logic [W:0]    rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    rem_sh;
   logic          ge;
   logic          finish;

   always_comb begin
      finish = busy_ff && (div_ff ? (cnt_ff == '0) : (mpr_ff == '0));
      rem_sh = {rem_ff[W-1:0], mpd_ff[W-1]};
      ge     = rem_sh >= {1'b0, mpr_ff};
      busy_in = busy_ff;
      div_in  = div_ff;
      acc_in  = acc_ff;
      mpd_in  = mpd_ff;
      mpr_in  = mpr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            div_in  = is_div;
            acc_in  = '0;
            mpd_in  = a;
            mpr_in  = b;
            rem_in  = '0;
            cnt_in  = CW'(W);
         end
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (div_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, mpr_ff}) : rem_sh;
         mpd_in = {mpd_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
      end else begin
         if (mpr_ff[0]) begin
            acc_in = acc_ff + mpd_ff;
         end
         mpd_in = {mpd_ff[W-2:0], 1'b0};
         mpr_in = {1'b0, mpr_ff[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      div_ff <= div_in;
      acc_ff <= acc_in;
      mpd_ff <= mpd_in;
      mpr_ff <= mpr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy   = busy_ff;
   assign done   = finish;
   assign result = div_ff ? mpd_ff : acc_ff;

endmodule

// File: rtl/hpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine controller
// Sequences the clearing pass, the bin walks and the arithmetic steps.
// ----------------------------------------------------------------------------
module hpe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  hpe_pkg::ctrl_status_type status,
   output hpe_pkg::ctrl_cmd_type    cmd
);

   hpe_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpe_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.ready = 1'b0;
      cmd.op    = hpe_pkg::DP_NOP;
      case (state_ff)
         hpe_pkg::ST_CLEAR: begin
            cmd.op = hpe_pkg::DP_CLEAR;
            if (status.clear_done) begin
               state_in = hpe_pkg::ST_IDLE;
            end
         end
         hpe_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.in_query) begin
               state_in = hpe_pkg::ST_START;
            end
         end
         hpe_pkg::ST_START: begin
            if (!status.span_ok) begin
               cmd.op   = hpe_pkg::DP_SET_BAD;
               state_in = hpe_pkg::ST_EMIT;
            end else if (status.is_vaf) begin
               state_in = hpe_pkg::ST_SUM_INIT;
            end else begin
               state_in = hpe_pkg::ST_POS_MUL;
            end
         end
         hpe_pkg::ST_POS_MUL: begin
            cmd.op = hpe_pkg::DP_POS_MUL;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_POS_DIV;
            end
         end
         hpe_pkg::ST_POS_DIV: begin
            cmd.op = hpe_pkg::DP_POS_DIV;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_SUM_INIT;
            end
         end
         hpe_pkg::ST_SUM_INIT: begin
            cmd.op   = hpe_pkg::DP_SUM_INIT;
            state_in = hpe_pkg::ST_SUM;
         end
         hpe_pkg::ST_SUM: begin
            cmd.op = hpe_pkg::DP_SUM;
            if (status.walk_done) begin
               state_in = hpe_pkg::ST_CHECK;
            end
         end
         hpe_pkg::ST_CHECK: begin
            if (status.early) begin
               cmd.op   = hpe_pkg::DP_SET_EARLY;
               state_in = hpe_pkg::ST_EMIT;
            end else if (status.is_vaf) begin
               state_in = hpe_pkg::ST_TGT_MUL;
            end else begin
               state_in = hpe_pkg::ST_NUM_MUL;
            end
         end
         hpe_pkg::ST_TGT_MUL: begin
            cmd.op = hpe_pkg::DP_TGT_MUL;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_FIND_INIT;
            end
         end
         hpe_pkg::ST_FIND_INIT: begin
            cmd.op   = hpe_pkg::DP_FIND_INIT;
            state_in = hpe_pkg::ST_FIND;
         end
         hpe_pkg::ST_FIND: begin
            cmd.op = hpe_pkg::DP_FIND;
            if (status.walk_done) begin
               if (!status.hit) begin
                  // The cumulative count never reached the target.
                  cmd.op   = hpe_pkg::DP_SET_HIGH;
                  state_in = hpe_pkg::ST_EMIT;
               end else if (status.cnt_zero) begin
                  state_in = hpe_pkg::ST_OFF_MUL;
               end else begin
                  state_in = hpe_pkg::ST_WITHIN_DIV;
               end
            end
         end
         hpe_pkg::ST_WITHIN_DIV: begin
            cmd.op = hpe_pkg::DP_WITHIN_DIV;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_OFF_MUL;
            end
         end
         hpe_pkg::ST_OFF_MUL: begin
            cmd.op = hpe_pkg::DP_OFF_MUL;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_OFF_DIV;
            end
         end
         hpe_pkg::ST_OFF_DIV: begin
            cmd.op = hpe_pkg::DP_OFF_DIV;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_EMIT;
            end
         end
         hpe_pkg::ST_NUM_MUL: begin
            cmd.op = hpe_pkg::DP_NUM_MUL;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_NUM_DIV;
            end
         end
         hpe_pkg::ST_NUM_DIV: begin
            cmd.op = hpe_pkg::DP_NUM_DIV;
            if (status.arith_done) begin
               state_in = hpe_pkg::ST_EMIT;
            end
         end
         hpe_pkg::ST_EMIT: begin
            if (status.slot_free) begin
               cmd.op   = hpe_pkg::DP_PUSH;
               state_in = hpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/hpe_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine datapath
// Bin memory, configuration, walk accumulators, arithmetic and result register.
// ----------------------------------------------------------------------------
module hpe_dpath #(
   parameter int MAX_BINS   = hpe_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = hpe_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  hpe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hpe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [hpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hpe_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  hpe_pkg::ctrl_cmd_type               cmd,
   output hpe_pkg::ctrl_status_type            status
);

   localparam int IDX_W = $clog2(MAX_BINS);
   localparam int NB_W  = hpe_pkg::BINS_W;
   localparam int TOT_W = COUNT_BITS + NB_W;
   localparam int AW    = (COUNT_BITS + 26 > 58) ? COUNT_BITS + 26 : 58;
   localparam logic [39:0] CNT_MAX = (40'd1 << COUNT_BITS) - 40'd1;

   // Configuration.
   logic signed [31:0] low_ff, low_in;
   logic signed [31:0] high_ff, high_in;
   logic [NB_W-1:0]    bins_ff, bins_in;

   hpe_pkg::req_type   req_ff, req_in;

   // Clearing pass and walk.
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [IDX_W:0]     rd_addr_ff, rd_addr_in;
   logic               proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]   proc_idx_ff, proc_idx_in;
   logic               walk_done_ff, walk_done_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [TOT_W-1:0]   cum_ff, cum_in;
   logic [COUNT_BITS-1:0] cnt_at_ff, cnt_at_in;
   logic [NB_W-1:0]    bin_ff, bin_in;
   logic [16:0]        part_ff, part_in;
   logic [AW-1:0]      target_ff, target_in;
   logic [16:0]        within_ff, within_in;

   // Results.
   hpe_pkg::rsp_type   res_ff, res_in;
   hpe_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Combinational helpers.
   logic [NB_W-1:0]    nb;
   logic [31:0]        span;
   logic [31:0]        dv;
   logic               span_ok;
   logic               accept;
   logic [39:0]        count_ext;
   logic [39:0]        count_sat;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic               walk_op;
   logic               issue;
   logic               proc;
   logic               last;
   logic [TOT_W-1:0]   next_cum;
   logic               reach;
   logic               arith_start;
   logic               arith_div;
   logic [AW-1:0]      arith_a;
   logic [AW-1:0]      arith_b;
   logic               arith_busy;
   logic               arith_done;
   logic [AW-1:0]      arith_res;
   logic [AW-1:0]      bin_full;
   logic [AW-1:0]      part_full;
   logic [NB_W-1:0]    bin_sel;
   logic [AW-1:0]      off_full;
   logic [31:0]        off;
   logic               early_vaf;
   logic               early_fav;
   logic               slot_free;

   always_comb begin
      nb      = (int'(bins_ff) > MAX_BINS) ? NB_W'(MAX_BINS) : bins_ff;
      span    = 32'(high_ff - low_ff);
      dv      = 32'(req_ff.query_value - low_ff);
      span_ok = (high_ff > low_ff) && (nb != '0);
      accept  = req_valid && cmd.ready;
      slot_free = !rsp_valid_ff || !rsp_stall;

      count_ext = 40'(req_data.bin_count);
      count_sat = (count_ext > CNT_MAX) ? CNT_MAX : count_ext;

      // The clearing pass and bin loads share the write port.
      if (cmd.op == hpe_pkg::DP_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = accept && (req_data.mode == hpe_pkg::MODE_LOAD)
                     && (int'(req_data.bin_index) < MAX_BINS);
         ram_waddr = IDX_W'(req_data.bin_index);
         ram_wdata = count_sat[COUNT_BITS-1:0];
      end

      walk_op  = (cmd.op == hpe_pkg::DP_SUM) || (cmd.op == hpe_pkg::DP_FIND);
      issue    = walk_op && !walk_done_ff && (int'(rd_addr_ff) < int'(nb));
      proc     = walk_op && proc_valid_ff && !walk_done_ff;
      last     = int'(proc_idx_ff) == int'(nb) - 1;
      next_cum = cum_ff + TOT_W'(ram_rdata);
      reach    = (AW'(next_cum) << 16) >= target_ff;

      arith_div = 1'b0;
      arith_a   = '0;
      arith_b   = '0;
      case (cmd.op)
         hpe_pkg::DP_POS_MUL: begin
            arith_a = AW'(dv);
            arith_b = AW'(nb) << 16;
         end
         hpe_pkg::DP_POS_DIV: begin
            arith_div = 1'b1;
            arith_a   = arith_res;
            arith_b   = AW'(span);
         end
         hpe_pkg::DP_TGT_MUL: begin
            arith_a = AW'(req_ff.fraction);
            arith_b = AW'(total_ff);
         end
         hpe_pkg::DP_WITHIN_DIV: begin
            arith_div = 1'b1;
            arith_a   = target_ff - (AW'(cum_ff) << 16);
            arith_b   = AW'(cnt_at_ff);
         end
         hpe_pkg::DP_OFF_MUL: begin
            arith_a = (AW'(hit_idx_ff) << 16) + AW'(within_ff);
            arith_b = AW'(span);
         end
         hpe_pkg::DP_OFF_DIV: begin
            arith_div = 1'b1;
            arith_a   = arith_res;
            arith_b   = AW'(nb) << 16;
         end
         hpe_pkg::DP_NUM_MUL: begin
            arith_a = AW'(cnt_at_ff);
            arith_b = AW'(part_ff);
         end
         hpe_pkg::DP_NUM_DIV: begin
            arith_div = 1'b1;
            arith_a   = (AW'(cum_ff) << 16) + arith_res;
            arith_b   = AW'(total_ff);
         end
         default: begin
            arith_div = 1'b0;
         end
      endcase
      arith_start = !arith_busy && (
         (cmd.op == hpe_pkg::DP_POS_MUL) || (cmd.op == hpe_pkg::DP_POS_DIV) ||
         (cmd.op == hpe_pkg::DP_TGT_MUL) || (cmd.op == hpe_pkg::DP_WITHIN_DIV) ||
         (cmd.op == hpe_pkg::DP_OFF_MUL) || (cmd.op == hpe_pkg::DP_OFF_DIV) ||
         (cmd.op == hpe_pkg::DP_NUM_MUL) || (cmd.op == hpe_pkg::DP_NUM_DIV));

      // Bin and in-bin position of the query value, and the offset clamped to the span.
      bin_full  = arith_res >> 16;
      bin_sel   = (bin_full > AW'(nb - NB_W'(1))) ? (nb - NB_W'(1)) : bin_full[NB_W-1:0];
      part_full = arith_res - (AW'(bin_sel) << 16);
      off_full  = (arith_res > AW'(span)) ? AW'(span) : arith_res;
      off       = off_full[31:0];

      early_vaf = (total_ff == '0) || (req_ff.fraction == '0) || req_ff.fraction[16];
      early_fav = (total_ff == '0) || (req_ff.query_value <= low_ff)
                  || (req_ff.query_value >= high_ff);
   end

   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      bins_in       = bins_ff;
      req_in        = accept ? req_data : req_ff;
      clr_addr_in   = clr_addr_ff;
      rd_addr_in    = rd_addr_ff;
      proc_valid_in = issue;
      proc_idx_in   = rd_addr_ff[IDX_W-1:0];
      walk_done_in  = walk_done_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      total_in      = total_ff;
      cum_in        = cum_ff;
      cnt_at_in     = cnt_at_ff;
      bin_in        = bin_ff;
      part_in       = part_ff;
      target_in     = target_ff;
      within_in     = within_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         case (csr_index)
            hpe_pkg::CSR_DATA_LOW:  low_in  = signed'(csr_wdata);
            hpe_pkg::CSR_DATA_HIGH: high_in = signed'(csr_wdata);
            hpe_pkg::CSR_BINS:      bins_in = csr_wdata[NB_W-1:0];
            default:                bins_in = bins_ff;
         endcase
      end

      if (issue) begin
         rd_addr_in = rd_addr_ff + (IDX_W+1)'(1);
      end

      case (cmd.op)
         hpe_pkg::DP_CLEAR: begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
         hpe_pkg::DP_SET_BAD: begin
            res_in.result_value    = '0;
            res_in.result_fraction = '0;
            res_in.histogram_valid = 1'b0;
         end
         hpe_pkg::DP_SUM_INIT, hpe_pkg::DP_FIND_INIT: begin
            rd_addr_in    = '0;
            proc_valid_in = 1'b0;
            walk_done_in  = 1'b0;
            hit_in        = 1'b0;
            cum_in        = '0;
            if (cmd.op == hpe_pkg::DP_SUM_INIT) begin
               total_in  = '0;
               cnt_at_in = '0;
            end
         end
         hpe_pkg::DP_SUM: begin
            if (proc) begin
               total_in = total_ff + TOT_W'(ram_rdata);
               if (int'(proc_idx_ff) < int'(bin_ff)) begin
                  cum_in = next_cum;
               end
               if (int'(proc_idx_ff) == int'(bin_ff)) begin
                  cnt_at_in = ram_rdata;
               end
               if (last) begin
                  walk_done_in = 1'b1;
               end
            end
         end
         hpe_pkg::DP_FIND: begin
            if (proc) begin
               if (reach) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = proc_idx_ff;
                  cnt_at_in    = ram_rdata;
                  within_in    = '0;
                  walk_done_in = 1'b1;
               end else begin
                  cum_in = next_cum;
                  if (last) begin
                     walk_done_in = 1'b1;
                  end
               end
            end
         end
         hpe_pkg::DP_SET_EARLY: begin
            res_in.histogram_valid = 1'b1;
            if (req_ff.mode == hpe_pkg::MODE_VAF) begin
               res_in.result_fraction = '0;
               res_in.result_value    = ((total_ff == '0) || (req_ff.fraction == '0))
                                        ? low_ff : high_ff;
            end else begin
               res_in.result_value    = '0;
               res_in.result_fraction = ((total_ff == '0)
                                        || (req_ff.query_value <= low_ff))
                                        ? 17'd0 : hpe_pkg::ONE_Q16;
            end
         end
         hpe_pkg::DP_SET_HIGH: begin
            res_in.result_value    = high_ff;
            res_in.result_fraction = '0;
            res_in.histogram_valid = 1'b1;
         end
         hpe_pkg::DP_POS_DIV: begin
            if (arith_done) begin
               bin_in  = bin_sel;
               part_in = (part_full > AW'(hpe_pkg::ONE_Q16)) ? hpe_pkg::ONE_Q16
                                                             : part_full[16:0];
            end
         end
         hpe_pkg::DP_TGT_MUL: begin
            if (arith_done) begin
               target_in = arith_res;
            end
         end
         hpe_pkg::DP_WITHIN_DIV: begin
            if (arith_done) begin
               within_in = arith_res[16:0];
            end
         end
         hpe_pkg::DP_OFF_DIV: begin
            if (arith_done) begin
               res_in.result_value    = low_ff + signed'(off);
               res_in.result_fraction = '0;
               res_in.histogram_valid = 1'b1;
            end
         end
         hpe_pkg::DP_NUM_DIV: begin
            if (arith_done) begin
               res_in.result_value    = '0;
               res_in.result_fraction = (arith_res > AW'(hpe_pkg::ONE_Q16))
                                        ? hpe_pkg::ONE_Q16 : arith_res[16:0];
               res_in.histogram_valid = 1'b1;
            end
         end
         hpe_pkg::DP_PUSH: begin
            rsp_in       = res_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= hpe_pkg::DATA_LOW_RST;
         high_ff       <= hpe_pkg::DATA_HIGH_RST;
         bins_ff       <= hpe_pkg::BINS_RST;
         clr_addr_ff   <= '0;
         rd_addr_ff    <= '0;
         proc_valid_ff <= 1'b0;
         walk_done_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         bins_ff       <= bins_in;
         clr_addr_ff   <= clr_addr_in;
         rd_addr_ff    <= rd_addr_in;
         proc_valid_ff <= proc_valid_in;
         walk_done_ff  <= walk_done_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      proc_idx_ff <= proc_idx_in;
      hit_idx_ff  <= hit_idx_in;
      total_ff    <= total_in;
      cum_ff      <= cum_in;
      cnt_at_ff   <= cnt_at_in;
      bin_ff      <= bin_in;
      part_ff     <= part_in;
      target_ff   <= target_in;
      within_ff   <= within_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   hpe_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   hpe_arith #(
      .W (AW)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (arith_start),
      .is_div (arith_div),
      .a      (arith_a),
      .b      (arith_b),
      .busy   (arith_busy),
      .done   (arith_done),
      .result (arith_res)
   );

   always_comb begin
      status.clear_done = (cmd.op == hpe_pkg::DP_CLEAR)
                          && (clr_addr_ff == IDX_W'(MAX_BINS - 1));
      status.span_ok    = span_ok;
      status.in_query   = req_valid && ((req_data.mode == hpe_pkg::MODE_VAF)
                          || (req_data.mode == hpe_pkg::MODE_FAV));
      status.is_vaf     = req_ff.mode == hpe_pkg::MODE_VAF;
      status.early      = (req_ff.mode == hpe_pkg::MODE_VAF) ? early_vaf : early_fav;
      status.walk_done  = walk_done_ff;
      status.hit        = hit_ff;
      status.cnt_zero   = cnt_at_ff == '0;
      status.arith_done = arith_done;
      status.slot_free  = slot_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/histogram_percentile_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine
// Bin count store with value-at-fraction and fraction-at-value queries.
// ----------------------------------------------------------------------------
// Usage: a transaction on the req_ channel with mode load writes one bin count
// and gives no result; it is taken without a stall and a load can follow every
// cycle while the engine is idle. A query transaction (value at fraction or
// fraction at value) gives exactly one transaction on the rsp_ channel.
// A query walks the bins in use once to form the total, one bin per cycle
// through the bin memory read port, and a value-at-fraction query walks them
// a second time to find the target bin. Multiplies and divides run in one
// shared shift-add / restoring unit, one bit per cycle; mode three is dropped.
// req_stall is high while a query is in progress. The finished result sits
// in an output register, so the next transaction is taken while the rsp_ side
// stalls. After reset a clearing pass zeroes the bin memory with req_stall
// high; the csr_ port may be written at any time the engine is idle.
// ----------------------------------------------------------------------------
module histogram_percentile_engine_top #(
   parameter int MAX_BINS   = hpe_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = hpe_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hpe_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hpe_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [hpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   hpe_pkg::ctrl_cmd_type    cmd;
   hpe_pkg::ctrl_status_type status;

   hpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   hpe_dpath #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_stall = !cmd.ready;

endmodule

// File: rtl/hpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine port checker
// Checks on the top level ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hpe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input hpe_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hpe_pkg::rsp_type rsp_data
);

   // A result transaction held by the receiver keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An invalid span gives zero in both result fields.
   a_bad_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.histogram_valid |->
         rsp_data.result_value == 0 && rsp_data.result_fraction == 0)
      else $error("nonzero result with invalid span");

   a_frac_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_fraction <= 17'h10000)
      else $error("result fraction above one");

   // A fraction answer never comes with a value answer.
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_fraction != 0 |-> rsp_data.result_value == 0)
      else $error("both result fields set");

endmodule

bind histogram_percentile_engine_top hpe_checker u_hpe_checker (.*);

// File: bench/tb_histogram_percentile_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram percentile engine testbench
// Loads bin counts and runs value-at-fraction and fraction-at-value queries
// under several span and bin settings. Each answer is compared with a fixed
// answer or an in-bench model of the engine. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_histogram_percentile_engine_top;
   import hpe_pkg::*;

   localparam int NBINS       = MAX_BINS_DEF;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 130;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DATA_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Model state.
   longint unsigned    bin_store [NBINS];
   logic signed [31:0] span_low;
   logic signed [31:0] span_high;
   logic [BINS_W-1:0]  bins_cfg;

   rsp_type answers_due [$];
   bit      idle_on = 1'b1;
   int      mismatches = 0;
   int      answers_seen = 0;
   int      loads_sent = 0;
   int      stall_left = 0;

   histogram_percentile_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("Timeout with %0d answers outstanding", answers_due.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type mk_req(logic [1:0] m, logic [7:0] idx, logic [31:0] cnt,
                                      logic [16:0] frac, logic [31:0] qv);
      req_type r;
      r.mode = m;
      r.bin_index = idx;
      r.bin_count = cnt;
      r.fraction = frac;
      r.query_value = qv;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [31:0] v, logic [16:0] f, logic ok);
      rsp_type o;
      o.result_value = v;
      o.result_fraction = f;
      o.histogram_valid = ok;
      return o;
   endfunction

   // Computes the answer to one transaction and applies loads to the bin store.
   function automatic bit engine_answer(input req_type r, output rsp_type o);
      longint unsigned nb, total, span, target, cum, nxt, c, in_bin, pos, off;
      longint unsigned posq, bin, part, num, q;
      longint          lo, hi, v, res;
      bit              found;
      o = '0;
      if (r.mode == MODE_LOAD) begin
         bin_store[r.bin_index] = r.bin_count;
         return 1'b0;
      end
      if (r.mode != MODE_VAF && r.mode != MODE_FAV) return 1'b0;
      nb = (bins_cfg > NBINS) ? NBINS : bins_cfg;
      lo = span_low;
      hi = span_high;
      if (!(hi > lo) || nb < 1) return 1'b1;
      o.histogram_valid = 1'b1;
      total = 0;
      for (int b = 0; b < nb; b++) total += bin_store[b];
      span = hi - lo;
      if (r.mode == MODE_VAF) begin
         if (r.fraction == 0 || total == 0) res = lo;
         else if (r.fraction >= ONE_Q16) res = hi;
         else begin
            target = longint'(r.fraction) * total;
            cum = 0;
            res = hi;
            found = 1'b0;
            for (int b = 0; b < nb && !found; b++) begin
               c = bin_store[b];
               nxt = cum + c;
               if ((nxt << 16) >= target) begin
                  in_bin = (c != 0) ? (target - (cum << 16)) / c : 0;
                  pos = (longint'(b) << 16) + in_bin;
                  off = (pos * span) / (nb << 16);
                  if (off > span) off = span;
                  res = lo + longint'(off);
                  found = 1'b1;
               end
               cum = nxt;
            end
         end
         o.result_value = res[31:0];
      end else begin
         v = r.query_value;
         if (total == 0 || v <= lo) q = 0;
         else if (v >= hi) q = ONE_Q16;
         else begin
            posq = (longint'(v - lo) * (nb << 16)) / span;
            bin = posq >> 16;
            if (bin > nb - 1) bin = nb - 1;
            part = posq - (bin << 16);
            if (part > ONE_Q16) part = ONE_Q16;
            cum = 0;
            for (int b = 0; b < bin; b++) cum += bin_store[b];
            num = (cum << 16) + bin_store[bin] * part;
            q = num / total;
            if (q > ONE_Q16) q = ONE_Q16;
         end
         o.result_fraction = q[16:0];
      end
      return 1'b1;
   endfunction

   task automatic idle_burst();
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Offers one transaction and records the answer it must give.
   task automatic send_item(req_type r, bit known, rsp_type known_rsp);
      rsp_type o;
      idle_burst();
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (engine_answer(r, o)) answers_due.push_back(known ? known_rsp : o);
      if (r.mode == MODE_LOAD) loads_sent++;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The write enable drops for one cycle between register writes.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DATA_LOW) span_low = val;
      else if (idx == CSR_DATA_HIGH) span_high = val;
      else bins_cfg = val[BINS_W-1:0];
      @(posedge clock);
   endtask

   // Response side: random stall bursts and the field comparison.
   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && !rsp_stall) begin
         answers_seen++;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected answer %p", rsp_data);
         end else begin
            want = answers_due.pop_front();
            if (rsp_data.result_value !== want.result_value ||
                rsp_data.result_fraction !== want.result_fraction ||
                rsp_data.histogram_valid !== want.histogram_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Answer mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      rsp_stall <= (stall_left > 0);
   end

   function automatic req_type random_item();
      int              pick;
      int unsigned     nb;
      logic [31:0]     cnt, qv;
      logic [16:0]     frac;
      logic [7:0]      idx;
      longint          span;
      nb = (bins_cfg == 0) ? 1 : ((bins_cfg > NBINS) ? NBINS : bins_cfg);
      idx = ($urandom_range(0, 6) != 0) ? $urandom_range(0, nb - 1) : $urandom_range(0, 255);
      case ($urandom_range(0, 3))
         0: cnt = 0;
         1: cnt = 32'hFFFF_FFFF;
         2: cnt = $urandom_range(0, 1000);
         default: cnt = $urandom;
      endcase
      case ($urandom_range(0, 4))
         0: frac = 0;
         1: frac = ONE_Q16;
         2: frac = $urandom_range(0, 131071);
         default: frac = $urandom_range(0, 65536);
      endcase
      span = longint'(span_high) - longint'(span_low);
      case ($urandom_range(0, 5))
         0: qv = span_low;
         1: qv = span_high;
         2: qv = $urandom;
         default: qv = (span > 0) ? 32'(longint'(span_low) + ($urandom % (span + 1))) : $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 55) return mk_req(MODE_LOAD, idx, cnt, frac, qv);
      if (pick < 75) return mk_req(MODE_VAF, idx, cnt, frac, qv);
      if (pick < 96) return mk_req(MODE_FAV, idx, cnt, frac, qv);
      return mk_req(MODE_SPARE, idx, cnt, frac, qv);
   endfunction

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      logic signed [31:0] lo, hi;
      logic [BINS_W-1:0]  nb;
      rsp_type none;
      none = '0;
      for (int b = 0; b < NBINS; b++) bin_store[b] = 0;
      span_low = DATA_LOW_RST;
      span_high = DATA_HIGH_RST;
      bins_cfg = BINS_RST;

      // Directed rows against the reset span 0 .. 16777216 with 256 bins.
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 0, 0), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, ONE_Q16, 0), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 100), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_LOAD, 0, 32'hFFFF_FFFF, 0, 0), 0, none});
      rows.push_back('{mk_req(MODE_LOAD, 255, 32'hFFFF_FFFF, 0, 0), 0, none});
      rows.push_back('{mk_req(MODE_LOAD, 128, 0, 0, 0), 0, none});
      rows.push_back('{mk_req(MODE_SPARE, 8'hFF, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF),
                       0, none});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, ONE_Q16, 0), 1, mk_rsp(DATA_HIGH_RST, 0, 1)});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 17'h1FFFF, 0), 1, mk_rsp(DATA_HIGH_RST, 0, 1)});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 0, 0), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 32'h8000_0000), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 32'h7FFF_FFFF), 1, mk_rsp(0, ONE_Q16, 1)});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 0), 1, mk_rsp(0, 0, 1)});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, DATA_HIGH_RST), 1, mk_rsp(0, ONE_Q16, 1)});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 32768, 0), 0, none});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 8388608), 0, none});
      rows.push_back('{mk_req(MODE_LOAD, 7, 12345, 0, 0), 0, none});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 1, 0), 0, none});
      rows.push_back('{mk_req(MODE_FAV, 0, 0, 0, 1), 0, none});
      rows.push_back('{mk_req(MODE_VAF, 0, 0, 65535, 0), 0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The bin memory is cleared after reset; wait for it to finish.
      while (req_stall) @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send_item(row.req, row.known, row.rsp);
      end
      // Hold off until every outstanding answer has returned.
      wait_quiet();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; nb = 256; end
            1: begin lo = -32'sd65536;  hi = 32'sd655360;   nb = 1;   end
            2: begin lo = 32'sd1000;    hi = 32'sd1000;     nb = 4;   end
            3: begin lo = 32'sd0;       hi = 32'sd65536;    nb = 0;   end
            4: begin lo = -32'sd4096;   hi = 32'sd8192;     nb = 511; end
            5: begin lo = 32'sd500;     hi = -32'sd500;     nb = 8;   end
            default: begin
               lo = $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 1 << 24);
               hi = lo + $urandom_range(1, 32'h7FFF_FFFF);
               if (hi <= lo) hi = 32'h7FFF_FFFF;
               nb = $urandom_range(1, 32);
            end
         endcase
         if (ph == PHASES - 2) idle_on = 1'b0;
         wait_quiet();
         csr_write(CSR_DATA_LOW, lo);
         csr_write(CSR_DATA_HIGH, hi);
         csr_write(CSR_BINS, 32'(nb));
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, none);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d loads and %0d query answers over %0d span settings.",
               loads_sent, answers_seen, PHASES + 1);
      $display("Mismatches: %0d, answers left over: %0d", mismatches, answers_due.size());
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
